>>> rtl/rlcg_pkg.sv
// shared types and constants for the ranged lcg generator
// no dependencies
`timescale 1ns / 1ps

package rlcg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ModeW = 2;
  localparam int unsigned StepW = 5;   // counts the 32 divider steps

  localparam logic [DataW-1:0] SeedReset = 32'd1063523561;

  // register indexes
  localparam logic REG_START_SEED = 1'b0;
  localparam logic REG_MODE       = 1'b1;

  // seed update modes
  localparam logic [ModeW-1:0] MODE_MOD32749   = 2'd0;
  localparam logic [ModeW-1:0] MODE_MOD2796203 = 2'd1;
  localparam logic [ModeW-1:0] MODE_SHIFTED    = 2'd2;

  localparam logic [DataW-1:0] Mul0 = 32'd32719;
  localparam logic [DataW-1:0] Add0 = 32'd3;
  localparam logic [DataW-1:0] Mod0 = 32'd32749;
  localparam logic [DataW-1:0] Mul1 = 32'd125;
  localparam logic [DataW-1:0] Mod1 = 32'd2796203;
  localparam logic [DataW-1:0] Mul2 = 32'd214013;
  localparam logic [DataW-1:0] Add2 = 32'd2531011;

  // floor(2^32 / modulus), quotient estimate is at most one short
  localparam logic [DataW-1:0] Rcp0 = 32'd131148;
  localparam logic [DataW-1:0] Rcp1 = 32'd1535;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_REDUCE,
    S_BACK,
    S_FIX,
    S_PICK,
    S_RANGE_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DataW-1:0] dividend;
    logic [DataW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] remainder;
  } div_rsp_t;

endpackage

>>> rtl/rlcg_divider.sv
// bit-serial restoring divider, remainder only, one bit per cycle
// depends on rlcg_pkg
`timescale 1ns / 1ps

module rlcg_divider
  import rlcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic             busy;
  logic             done;
  logic [StepW-1:0] count;
  logic [DataW-1:0] rem;
  logic [DataW-1:0] dvd;
  logic [DataW-1:0] dvs;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;

  assign trial = {rem, dvd[DataW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == {StepW{1'b1}}) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvd <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      // keep the trial difference when it does not go negative
      rem <= diff[DataW] ? trial[DataW-1:0] : diff[DataW-1:0];
      dvd <= {dvd[DataW-2:0], 1'b0};
    end
  end

  assign rsp.done      = done;
  assign rsp.remainder = rem;

endmodule

>>> rtl/ranged_lcg_random_generator.sv
// ranged lcg random generator, top level: sequencer, seed update and registers
// depends on rlcg_pkg and rlcg_divider
// a request walks S_MUL, S_REDUCE, S_BACK, S_FIX, S_PICK, S_RANGE_WAIT to S_DONE;
//   the shifted mode skips S_BACK and S_FIX, the full range skips the divide, and
//   an empty range goes straight to S_DONE; one request at a time, the next taken in
//   S_IDLE after out_valid with out_ready high; reset: seed 1063523561, mode 0, idle
`timescale 1ns / 1ps

module ranged_lcg_random_generator
  import rlcg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // configuration writes
  input  logic             cfg_write,
  input  logic             cfg_index,
  input  logic [DataW-1:0] cfg_data,
  // request channel
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DataW-1:0] minimum,
  input  logic [DataW-1:0] maximum,
  // result channel
  output logic             out_valid,
  input  logic             out_ready,
  output logic [DataW-1:0] value
);

  state_t state, state_next;

  logic [DataW-1:0] seed;
  logic [ModeW-1:0] mode;
  logic [DataW-1:0] lo;
  logic [DataW-1:0] width;   // maximum - minimum + 1, zero for the full range
  logic [DataW-1:0] prod;    // seed times multiplier plus increment, wrapped
  logic [DataW-1:0] quot;    // reciprocal estimate of prod / modulus
  logic [DataW-1:0] resid;   // prod - quot * modulus, below twice the modulus
  logic [DataW-1:0] result;

  logic             in_accept;
  logic             shifted_mode;
  logic [DataW-1:0] mul_k;
  logic [DataW-1:0] add_k;
  logic [DataW-1:0] mod_k;
  logic [DataW-1:0] rcp_k;

  logic [DataW-1:0]   mul_a;
  logic [DataW-1:0]   mul_b;
  logic [2*DataW-1:0] mul_p;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign in_accept    = in_valid && in_ready;
  assign shifted_mode = (mode == MODE_SHIFTED);

  // per-mode constants; the unused fourth mode behaves as mode 0
  always_comb begin
    unique case (mode)
      MODE_MOD2796203: begin
        mul_k = Mul1;
        add_k = '0;
        mod_k = Mod1;
        rcp_k = Rcp1;
      end
      MODE_SHIFTED: begin
        mul_k = Mul2;
        add_k = Add2;
        mod_k = Mod0;
        rcp_k = Rcp0;
      end
      default: begin
        mul_k = Mul0;
        add_k = Add0;
        mod_k = Mod0;
        rcp_k = Rcp0;
      end
    endcase
  end

  // one multiplier, shared by the seed product, the quotient estimate
  // and the back-multiply of the estimate
  always_comb begin
    mul_a = seed;
    mul_b = mul_k;
    if (state == S_REDUCE) begin
      mul_a = prod;
      mul_b = rcp_k;
    end else if (state == S_BACK) begin
      mul_a = quot;
      mul_b = mod_k;
    end
  end

  assign mul_p = {{DataW{1'b0}}, mul_a} * {{DataW{1'b0}}, mul_b};

  // the divider serves the range pick only
  always_comb begin
    div_req.start    = (state == S_PICK) && (width != '0);
    div_req.dividend = seed;
    div_req.divisor  = width;
  end

  rlcg_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          // empty range goes straight to the result
          state_next = (maximum > minimum) ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        state_next = S_REDUCE;
      end
      S_REDUCE: begin
        state_next = shifted_mode ? S_PICK : S_BACK;
      end
      S_BACK: begin
        state_next = S_FIX;
      end
      S_FIX: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        // full range: no modulo, the seed itself is the pick
        state_next = (width == '0) ? S_DONE : S_RANGE_WAIT;
      end
      S_RANGE_WAIT: begin
        if (div_rsp.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // configuration and seed state
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SeedReset;
      mode <= MODE_MOD32749;
    end else if (cfg_write) begin
      if (cfg_index == REG_START_SEED) begin
        seed <= cfg_data;
      end else begin
        mode <= cfg_data[ModeW-1:0];
      end
    end else if (state == S_REDUCE && shifted_mode) begin
      // (x >> 16) & 32767 of the wrapped product
      seed <= {{(DataW-15){1'b0}}, prod[30:16]};
    end else if (state == S_FIX) begin
      // estimate may be one short, one conditional subtract finishes it
      seed <= (resid >= mod_k) ? resid - mod_k : resid;
    end
  end

  // request datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lo     <= minimum;
      width  <= maximum - minimum + 32'd1;
      result <= minimum;
    end
    if (state == S_MUL) begin
      prod <= mul_p[DataW-1:0] + add_k;
    end
    if (state == S_REDUCE) begin
      quot <= mul_p[2*DataW-1:DataW];
    end
    if (state == S_BACK) begin
      resid <= prod - mul_p[DataW-1:0];
    end
    if (state == S_PICK && width == '0) begin
      result <= seed + lo;
    end
    if (state == S_RANGE_WAIT && div_rsp.done) begin
      result <= div_rsp.remainder + lo;
    end
  end

  assign value = result;

endmodule

>>> rtl/rlcg_checker.sv
// port-level checks for the ranged lcg generator, bound to the top level
// depends on rlcg_pkg
`timescale 1ns / 1ps

module rlcg_checker
  import rlcg_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic [DataW-1:0] minimum,
  input logic [DataW-1:0] maximum,
  input logic             out_valid,
  input logic             out_ready,
  input logic [DataW-1:0] value
);

  // a pending result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value))
    else $error("result changed while stalled");

  // one request in flight: no new request right after one is taken
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // an empty range answers with minimum on the next cycle
  a_empty: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !(maximum > minimum)
      |=> out_valid && value == $past(minimum))
    else $error("empty range result wrong");

  // no request taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("ready while result pending");

  // after a result is taken the block is free again
  a_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> in_ready && !out_valid)
    else $error("not idle after result taken");

endmodule

bind ranged_lcg_random_generator rlcg_checker u_rlcg_checker (.*);

>>> bench/ranged_lcg_random_generator_test.sv
// self-checking bench for ranged_lcg_random_generator: directed table, then random phases
// depends on rlcg_pkg and the generator rtl (top level plus divider)
`timescale 1ns / 1ps

module ranged_lcg_random_generator_test;
  import rlcg_pkg::*;

  // mode 3 has no name in the package, it behaves like the 32749 rule
  localparam logic [ModeW-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned DrainCycles = 80;

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic             cfg_index;
  logic [DataW-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [DataW-1:0] minimum;
  logic [DataW-1:0] maximum;
  logic             out_valid;
  logic             out_ready;
  logic [DataW-1:0] value;

  ranged_lcg_random_generator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .minimum   (minimum),
    .maximum   (maximum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value)
  );

  // one row of the directed table; known marks a value that is plain from the spec
  typedef struct packed {
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic             known;
    logic [DataW-1:0] val;
  } directed_row_t;

  // one random phase: a mode write (data may be wide), then an optional seed reload
  typedef struct packed {
    logic             load_seed;
    logic [DataW-1:0] seed;
    logic [DataW-1:0] mode_data;
    logic             steady;
    logic             hold_off;
  } phase_t;

  // own copy of the generator state
  logic [DataW-1:0] gen_seed;
  logic [ModeW-1:0] gen_mode;

  logic [DataW-1:0] expected_values[$];
  int unsigned      mismatch_count;
  int unsigned      cycle_count;
  bit               steady;        // no idling on either side while set
  bit               hold_request;  // asks the receiver for one long stall

  directed_row_t directed_rows [0:15];
  phase_t        phases [0:7];

  // seed update, products and sums wrap at 32 bits
  function automatic logic [DataW-1:0] advance_seed(input logic [DataW-1:0] s,
                                                    input logic [ModeW-1:0] mode);
    logic [DataW-1:0] prod;
    case (mode)
      MODE_MOD2796203: begin
        prod = s * Mul1;
        return prod % Mod1;
      end
      MODE_SHIFTED: begin
        prod = s * Mul2 + Add2;
        return (prod >> 16) & 32'd32767;
      end
      default: begin
        // 32749 rule, also taken by the spare mode
        prod = s * Mul0 + Add0;
        return prod % Mod0;
      end
    endcase
  endfunction

  // value for one request; moves the predicted seed when the range is not empty
  function automatic logic [DataW-1:0] ranged_value(input logic [DataW-1:0] lo,
                                                    input logic [DataW-1:0] hi);
    logic [DataW-1:0] span;
    logic [DataW-1:0] pick;
    if (hi <= lo) return lo;
    gen_seed = advance_seed(gen_seed, gen_mode);
    span = hi - lo + 1'b1;
    // full range: span wraps to zero and the raw seed is used
    pick = (span == '0) ? gen_seed : gen_seed % span;
    return pick + lo;
  endfunction

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on demand, none in steady phases
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // block fills up behind this while the sender keeps offering
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    logic [DataW-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (expected_values.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual %h", $time, value);
      end else begin
        want = expected_values.pop_front();
        if (value !== want) begin
          mismatch_count++;
          $display("%0t: value mismatch, expected %h actual %h", $time, want, value);
        end
      end
    end
  end

  // offer one request, hold it until accepted, then queue its expected value
  task automatic send_request(input logic [DataW-1:0] lo, input logic [DataW-1:0] hi,
                              input logic known, input logic [DataW-1:0] known_val);
    logic [DataW-1:0] predicted;
    while (!steady && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    minimum  <= lo;
    maximum  <= hi;
    do @(posedge clk); while (!in_ready);
    predicted = ranged_value(lo, hi);
    expected_values.push_back(known ? known_val : predicted);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_values.size() != 0) @(negedge clk);
  endtask

  // register writes, only while nothing is in flight
  task automatic apply_phase(input phase_t ph);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= ph.mode_data;
    gen_mode = ph.mode_data[ModeW-1:0];  // upper bits are dropped
    @(negedge clk);
    if (ph.load_seed) begin
      cfg_index <= REG_START_SEED;
      cfg_data  <= ph.seed;
      gen_seed = ph.seed;
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  // random request mix: empty, full, narrow, power-of-two and wide ranges
  task automatic send_random_request();
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] tmp;
    int unsigned      kind;
    kind = $urandom_range(0, 99);
    lo = $urandom;
    hi = $urandom;
    if (kind < 10) begin
      if (hi > lo) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
    end else if (kind < 15) begin
      lo = '0;
      hi = '1;
    end else if (kind < 40) begin
      hi = lo + $urandom_range(1, 255);
    end else if (kind < 55) begin
      hi = lo + ((32'd1 << $urandom_range(1, 31)) - 1'b1);
    end else if (kind < 62) begin
      lo = $urandom_range(0, 15);
    end else begin
      if (hi < lo) begin
        tmp = lo;
        lo = hi;
        hi = tmp;
      end
    end
    send_request(lo, hi, 1'b0, '0);
  endtask

  initial begin
    // everything known from time zero
    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = REG_START_SEED;
    cfg_data       = '0;
    in_valid       = 1'b0;
    minimum        = '0;
    maximum        = '0;
    steady         = 1'b0;
    hold_request   = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    gen_seed       = SeedReset;
    gen_mode       = MODE_MOD32749;

    // directed rows run at the reset settings
    directed_rows = '{
      '{32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},  // empty, both zero
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},  // empty, both max
      '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},  // reversed extremes
      '{32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0001},
      '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},          // full range wraps
      '{32'h0000_0000, 32'h0000_0001, 1'b0, 32'h0},
      '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'd12345,     32'd12345,     1'b1, 32'd12345},
      '{32'd100,       32'd199,       1'b0, 32'h0},
      '{32'h0000_0000, 32'hFFFF_FFFE, 1'b0, 32'h0},
      '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 32'hAAAA_AAAA},
      '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
      '{32'h0000_0000, 32'h0000_FFFF, 1'b0, 32'h0},
      '{32'hDEAD_BEEF, 32'hDEAD_BEF0, 1'b0, 32'h0}
    };

    // settings walk: seed extremes, every mode, the spare mode, wide mode data
    phases = '{
      '{1'b1, 32'h0000_0000, {30'd0, MODE_MOD32749},   1'b0, 1'b0},
      '{1'b1, 32'hFFFF_FFFF, {30'd0, MODE_MOD2796203}, 1'b0, 1'b0},
      '{1'b1, $urandom,      {30'd0, MODE_SHIFTED},    1'b0, 1'b0},
      '{1'b0, 32'h0000_0000, {30'd0, MODE_SPARE},      1'b1, 1'b0},
      '{1'b1, $urandom,      32'hFFFF_FFFD,            1'b0, 1'b0},
      '{1'b1, 32'h0000_0001, 32'hFFFF_FFFE,            1'b0, 1'b1},
      '{1'b1, $urandom,      32'h7FFF_FFFC,            1'b0, 1'b0},
      '{1'b1, 32'hFFFF_FFFF, {30'd0, MODE_SHIFTED},    1'b0, 1'b0}
    };

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed part, reset seed and mode 0
    foreach (directed_rows[i])
      send_request(directed_rows[i].lo, directed_rows[i].hi,
                   directed_rows[i].known, directed_rows[i].val);

    // random phases
    foreach (phases[p]) begin
      apply_phase(phases[p]);
      steady = phases[p].steady;
      for (int unsigned n = 0; n < PhaseItems; n++) begin
        // long receiver stall in the middle of the phase, sender keeps going
        if (phases[p].hold_off && n == PhaseItems / 2) hold_request = 1'b1;
        send_random_request();
      end
    end
    steady = 1'b0;

    // let the last results come back, then a short quiet tail
    wait_drained();
    repeat (DrainCycles) @(negedge clk);
    if (expected_values.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_values.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
